// ===== rtl/nnt_pkg.sv =====
// Shared constants and types for the nearest-neighbor tour builder.
// No dependencies; imported by nnt_best and nearest_neighbour_tour.
package nnt_pkg;

  localparam int unsigned NODES_DEF   = 64;
  localparam int unsigned DIST_W_DEF  = 16;

  // Fixed port field widths
  localparam int unsigned NODE_PORT_W = 6;
  localparam int unsigned DIST_PORT_W = 16;
  localparam int unsigned COST_W      = 22;
  localparam int unsigned CNT_W       = 7;

  localparam logic [COST_W-1:0] COST_MAX       = '1;
  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 7'd64;

  // Control of the running-minimum unit
  typedef struct packed {
    logic vld;    // a candidate distance is present
    logic first;  // first candidate of a scan, always taken
    logic tail;   // candidate is the last list entry
  } best_req_t;

endpackage

// ===== rtl/nnt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nnt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/nnt_best.sv =====
// Running-minimum unit: compares one candidate distance per cycle against
// the best so far and keeps its list index and node, and the node of the tail entry. Depends on nnt_pkg.
module nnt_best
  import nnt_pkg::*;
#(
  parameter int unsigned NW = 6,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  best_req_t     req_i,
  input  logic [NW-1:0] idx_i,
  input  logic [NW-1:0] node_i,
  input  logic [DW-1:0] dist_i,
  output logic [NW-1:0] best_idx_o,
  output logic [NW-1:0] best_node_o,
  output logic [DW-1:0] best_dist_o,
  output logic [NW-1:0] tail_node_o
);

  logic take;

  // strict compare: the earliest of equal distances wins
  assign take = req_i.vld && (req_i.first || (dist_i < best_dist_o));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_idx_o  <= '0;
      best_node_o <= '0;
      best_dist_o <= '0;
      tail_node_o <= '0;
    end else begin
      if (take) begin
        best_idx_o  <= idx_i;
        best_node_o <= node_i;
        best_dist_o <= dist_i;
      end
      if (req_i.vld && req_i.tail) begin
        tail_node_o <= node_i;
      end
    end
  end

endmodule

// ===== rtl/nearest_neighbour_tour.sv =====
// Nearest-neighbor tour builder over an asymmetric distance matrix held in RAM.
// A mode-0 request writes one matrix entry if row and column are in range. A mode-1
// request builds a greedy tour of node_count nodes from start_node and returns one
// result per node; input stall stays high for the whole build. The build first
// rebuilds the unvisited list, then for each step scans the remaining entries one
// per cycle through the list RAM, the distance RAM and a shared comparator, and
// finally adds the return leg to the start node.
module nearest_neighbour_tour
  import nnt_pkg::*;
#(
  parameter int unsigned MAX_NODES = NODES_DEF,
  parameter int unsigned DIST_BITS = DIST_W_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   node_count_we_i,
  input  logic [CNT_W-1:0]       node_count_i,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   mode_i,
  input  logic [NODE_PORT_W-1:0] row_i,
  input  logic [NODE_PORT_W-1:0] col_i,
  input  logic [DIST_PORT_W-1:0] distance_i,
  input  logic [NODE_PORT_W-1:0] start_node_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [NODE_PORT_W-1:0] position_o,
  output logic [NODE_PORT_W-1:0] tour_node_o,
  output logic [DIST_PORT_W-1:0] step_distance_o,
  output logic [COST_W-1:0]      tour_cost_o,
  output logic                   last_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned AW = $clog2(MAX_NODES * MAX_NODES);
  localparam int unsigned SW = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;
  localparam logic [AW-1:0] NODES_A = AW'(MAX_NODES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_EMIT, ST_SCAN, ST_UPD, ST_RET, ST_RET_W
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       node_count_q;
  logic [CW-1:0]          n_q;
  logic [NW-1:0]          first_q, cur_q, j_q, tail_q, pos_q, j1_q, j2_q, node2_q;
  logic [AW-1:0]          cur_base_q;
  logic [DIST_BITS-1:0]   step_q;
  logic [COST_W-1:0]      cost_q;
  logic                   last_q, iss_q, v1_q, v2_q, out_valid_q;
  logic [NODE_PORT_W-1:0] pos_out_q, node_out_q;
  logic [DIST_PORT_W-1:0] step_out_q;
  logic [COST_W-1:0]      cost_out_q;
  logic                   last_out_q;

  logic                   in_fire;
  logic [NW+NODE_PORT_W-1:0] row_x, col_x, start_x, pos_x, node_x;
  logic [DIST_BITS+DIST_PORT_W-1:0] dist_x, step_x;
  logic                   row_ok, col_ok;
  logic [CW-1:0]          n_new;
  logic [NW-1:0]          s_new, n_last;

  logic                   list_we;
  logic [NW-1:0]          list_waddr, list_wdata, list_rdata;
  logic                   dist_we;
  logic [AW-1:0]          dist_waddr, dist_raddr;
  logic [DIST_BITS-1:0]   dist_rdata;

  best_req_t              best_req;
  logic [NW-1:0]          best_idx, best_node, tail_node;
  logic [DIST_BITS-1:0]   best_dist, add_op;
  logic [SW-1:0]          sum;
  logic [COST_W-1:0]      sat_sum;
  logic                   scan_end, next_last;
  logic                   emit_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // request decode
  assign row_x   = {{NW{1'b0}}, row_i};
  assign col_x   = {{NW{1'b0}}, col_i};
  assign start_x = {{NW{1'b0}}, start_node_i};
  assign dist_x  = {{DIST_BITS{1'b0}}, distance_i};
  assign row_ok  = (32'(row_x) < MAX_NODES);
  assign col_ok  = (32'(col_x) < MAX_NODES);

  always_comb begin
    if (node_count_q == '0) begin
      n_new = CW'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n_new = CW'(MAX_NODES);
    end else begin
      n_new = CW'(node_count_q);
    end
  end

  assign s_new  = (32'(start_x) < 32'(n_new)) ? start_x[NW-1:0] : '0;
  assign n_last = NW'(n_q - CW'(1));

  // distance matrix
  assign dist_we    = in_fire && !mode_i && row_ok && col_ok;
  assign dist_waddr = AW'(row_x[NW-1:0]) * NODES_A + AW'(col_x[NW-1:0]);
  assign dist_raddr = (state_q == ST_RET) ? (cur_base_q + AW'(first_q))
                                          : (cur_base_q + AW'(list_rdata));

  nnt_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (MAX_NODES * MAX_NODES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_x[DIST_BITS-1:0]),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  // unvisited list: rebuilt as 0..n-1 with the start slot already holding n-1;
  // a taken entry is overwritten by the tail entry
  assign list_we    = (state_q == ST_INIT) || (state_q == ST_UPD);
  assign list_waddr = (state_q == ST_INIT) ? j_q : best_idx;
  assign list_wdata = (state_q == ST_INIT) ? ((j_q == first_q) ? n_last : j_q)
                                           : tail_node;

  nnt_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_NODES)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .raddr_i (j_q),
    .rdata_o (list_rdata)
  );

  // scan candidates reach the comparator after the list RAM read and the distance RAM read
  assign best_req.vld   = v2_q;
  assign best_req.first = (j2_q == '0);
  assign best_req.tail  = (j2_q == tail_q - NW'(1));

  nnt_best #(
    .NW (NW),
    .DW (DIST_BITS)
  ) u_best (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (best_req),
    .idx_i       (j2_q),
    .node_i      (node2_q),
    .dist_i      (dist_rdata),
    .best_idx_o  (best_idx),
    .best_node_o (best_node),
    .best_dist_o (best_dist),
    .tail_node_o (tail_node)
  );

  assign scan_end = v2_q && best_req.tail;

  // shared saturating cost adder: step distance or return leg
  assign add_op    = (state_q == ST_RET_W) ? dist_rdata : best_dist;
  assign sum       = SW'(cost_q) + SW'(add_op);
  assign sat_sum   = (sum > SW'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
  assign next_last = ((pos_q + NW'(1)) == n_last);

  // output register free or being drained this cycle
  assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  assign pos_x  = {{NODE_PORT_W{1'b0}}, pos_q};
  assign node_x = {{NODE_PORT_W{1'b0}}, cur_q};
  assign step_x = {{DIST_PORT_W{1'b0}}, step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (node_count_we_i) begin
      node_count_q <= node_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      first_q     <= '0;
      cur_q       <= '0;
      cur_base_q  <= '0;
      j_q         <= '0;
      tail_q      <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      cost_q      <= '0;
      last_q      <= 1'b0;
      iss_q       <= 1'b0;
      v1_q        <= 1'b0;
      j1_q        <= '0;
      v2_q        <= 1'b0;
      j2_q        <= '0;
      node2_q     <= '0;
      out_valid_q <= 1'b0;
      pos_out_q   <= '0;
      node_out_q  <= '0;
      step_out_q  <= '0;
      cost_out_q  <= '0;
      last_out_q  <= 1'b0;
    end else begin
      v1_q        <= (state_q == ST_SCAN) && iss_q;
      v2_q        <= v1_q;
      j2_q        <= j1_q;
      node2_q     <= list_rdata;
      out_valid_q <= emit_load || (out_valid_q && out_stall_i);

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && mode_i) begin
            n_q        <= n_new;
            first_q    <= s_new;
            cur_q      <= s_new;
            cur_base_q <= AW'(s_new) * NODES_A;
            j_q        <= '0;
            tail_q     <= NW'(n_new - CW'(1));
            pos_q      <= '0;
            step_q     <= '0;
            cost_q     <= '0;
            last_q     <= (n_new == CW'(1));
            state_q    <= ST_INIT;
          end
        end
        ST_INIT: begin
          j_q <= j_q + NW'(1);
          if (j_q == n_last) begin
            state_q <= last_q ? ST_RET : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            pos_out_q   <= pos_x[NODE_PORT_W-1:0];
            node_out_q  <= node_x[NODE_PORT_W-1:0];
            step_out_q  <= step_x[DIST_PORT_W-1:0];
            cost_out_q  <= cost_q;
            last_out_q  <= last_q;
            if (last_q) begin
              state_q <= ST_IDLE;
            end else begin
              j_q     <= '0;
              iss_q   <= 1'b1;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (iss_q) begin
            j1_q <= j_q;
            j_q  <= j_q + NW'(1);
            if (j_q == tail_q - NW'(1)) begin
              iss_q <= 1'b0;
            end
          end
          if (scan_end) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          cur_q      <= best_node;
          cur_base_q <= AW'(best_node) * NODES_A;
          cost_q     <= sat_sum;
          step_q     <= best_dist;
          pos_q      <= pos_q + NW'(1);
          tail_q     <= tail_q - NW'(1);
          last_q     <= next_last;
          state_q    <= next_last ? ST_RET : ST_EMIT;
        end
        ST_RET: begin
          state_q <= ST_RET_W;
        end
        ST_RET_W: begin
          cost_q  <= sat_sum;
          state_q <= ST_EMIT;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign position_o      = pos_out_q;
  assign tour_node_o     = node_out_q;
  assign step_distance_o = step_out_q;
  assign tour_cost_o     = cost_out_q;
  assign last_o          = last_out_q;

`ifndef ASSERT_OFF
  // the chosen slot must lie inside the live part of the list
  a_best_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (best_idx < tail_q))
    else $error("best index outside unvisited list");

  // row base address tracks the current node during a scan
  a_base_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cur_base_q == AW'(cur_q) * NODES_A))
    else $error("row base out of step with current node");

  // a tour request blocks further requests on the next cycle
  a_start_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_i) |=> in_stall_o)
    else $error("request accepted while a tour is being built");
`endif

endmodule
